@@ sv/quaternion_rotate_vector_defines.svh @@
// assertion macros for the quaternion rotation rtl
// no dependencies; files that check their own logic include this header
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define QRV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qrv assertion failed");
`define QRV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qrv implication failed");
`else
`define QRV_ASSERT(lbl, clk, rstn, prop)
`define QRV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/qrv_pkg.sv @@
// widths, stage indexes and stream packing for the quaternion rotation pipeline
// no dependencies; used by qrv_row and quaternion_rotate_vector
`default_nettype none
package qrv_pkg;

    localparam int VEC_WIDTH      = 16;
    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;

    // rotation matrix entries: sums of four 2*QW products
    localparam int MAT_WIDTH  = 2 * QUAT_WIDTH + 3;
    localparam int PROD_WIDTH = MAT_WIDTH + VEC_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int RND_SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int QUO_WIDTH  = SUM_WIDTH - RND_SHIFT;

    // pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int STG_QPROD  = 0;
    localparam int STG_MAT    = 1;
    localparam int STG_VPROD  = 2;
    localparam int STG_SUM    = 3;
    localparam int STG_OUT    = 4;

    localparam int IN_FIELDS_W  = 4 * QUAT_WIDTH + 3 * VEC_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * VEC_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [VEC_WIDTH-1:0] vec_comp_t;
    typedef logic signed [MAT_WIDTH-1:0] mat_entry_t;
    typedef logic [NUM_STAGES-1:0]       stage_en_t;

endpackage
`default_nettype wire

@@ sv/qrv_row.sv @@
// one row of the rotation: three entry-by-component products, their sum,
// round half up and saturate; depends on qrv_pkg, stage enables from the top level
`default_nettype none
module qrv_row
    import qrv_pkg::*;
(
    input  wire logic       aclk,
    input  wire stage_en_t  stage_en,
    input  wire mat_entry_t mat_0,
    input  wire mat_entry_t mat_1,
    input  wire mat_entry_t mat_2,
    input  wire vec_comp_t  vec_0,
    input  wire vec_comp_t  vec_1,
    input  wire vec_comp_t  vec_2,
    output vec_comp_t       res,
    output logic            ovf
);

    localparam logic signed [SUM_WIDTH-1:0] RND_HALF =
        {{(SUM_WIDTH - RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT - 1){1'b0}}};
    localparam vec_comp_t VEC_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam vec_comp_t VEC_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    logic signed [PROD_WIDTH-1:0] prod_reg [3];
    logic signed [SUM_WIDTH-1:0]  sum_reg;
    logic signed [SUM_WIDTH-1:0]  rnd;
    logic signed [QUO_WIDTH-1:0]  quo;
    logic                         ovf_next;
    vec_comp_t                    res_next;
    vec_comp_t                    res_reg;
    logic                         ovf_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[STG_VPROD]) begin
            prod_reg[0] <= PROD_WIDTH'(mat_0) * PROD_WIDTH'(vec_0);
            prod_reg[1] <= PROD_WIDTH'(mat_1) * PROD_WIDTH'(vec_1);
            prod_reg[2] <= PROD_WIDTH'(mat_2) * PROD_WIDTH'(vec_2);
        end
        if (stage_en[STG_SUM]) begin
            sum_reg <= SUM_WIDTH'(prod_reg[0]) + SUM_WIDTH'(prod_reg[1])
                     + SUM_WIDTH'(prod_reg[2]);
        end
        if (stage_en[STG_OUT]) begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    // dropping the low bits of a two's complement value is a floor
    always_comb begin
        rnd      = sum_reg + RND_HALF;
        quo      = rnd[SUM_WIDTH-1:RND_SHIFT];
        ovf_next = !((&quo[QUO_WIDTH-1:VEC_WIDTH-1]) || !(|quo[QUO_WIDTH-1:VEC_WIDTH-1]));
        if (ovf_next) begin
            res_next = quo[QUO_WIDTH-1] ? VEC_MIN : VEC_MAX;
        end else begin
            res_next = quo[VEC_WIDTH-1:0];
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule
`default_nettype wire

@@ sv/quaternion_rotate_vector.sv @@
// quaternion rotation of a 3-vector, signed Q2.14 quaternion, 16-bit vector
// one transaction per cycle throughput while no backpressure stalls the output,
// set by the five-stage multiply/add pipeline (depends on qrv_pkg, qrv_row)
// backpressure stalls only the stages that are full; empty stages keep filling
// synchronous active-low reset clears all stage valid bits, data regs not reset
`default_nettype none
`include "quaternion_rotate_vector_defines.svh"
module quaternion_rotate_vector
    import qrv_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // world_frame
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_x, out_y, out_z
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // overflow
    output logic                        m_axis_tuser
);

    localparam int QW = QUAT_WIDTH;
    localparam int VW = VEC_WIDTH;

    typedef logic signed [2*QW-1:0] qprod_t;

    stage_en_t stage_en;
    stage_en_t vld_reg;
    stage_en_t vld_next;

    logic signed [QW-1:0] in_w, in_x, in_y, in_z;
    vec_comp_t            in_r [3];

    // stage 0: quaternion products
    qprod_t    ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    qprod_t    wx_reg, wy_reg, wz_reg;
    logic      tg_reg;
    vec_comp_t r0_reg [3];

    // stage 1: rotation matrix
    mat_entry_t mat_reg [3][3];
    vec_comp_t  r1_reg  [3];
    mat_entry_t mat_next [3][3];
    mat_entry_t cx, cy, cz;

    vec_comp_t row_res [3];
    logic      row_ovf [3];

    assign in_w    = s_axis_tdata[QW-1:0];
    assign in_x    = s_axis_tdata[2*QW-1:QW];
    assign in_y    = s_axis_tdata[3*QW-1:2*QW];
    assign in_z    = s_axis_tdata[4*QW-1:3*QW];
    assign in_r[0] = s_axis_tdata[4*QW+VW-1:4*QW];
    assign in_r[1] = s_axis_tdata[4*QW+2*VW-1:4*QW+VW];
    assign in_r[2] = s_axis_tdata[4*QW+3*VW-1:4*QW+2*VW];

    // a stage may load when it is empty or the next one loads too
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
        vld_next[0] = stage_en[0] ? s_axis_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = stage_en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[STG_QPROD]) begin
            ww_reg <= qprod_t'(in_w) * qprod_t'(in_w);
            xx_reg <= qprod_t'(in_x) * qprod_t'(in_x);
            yy_reg <= qprod_t'(in_y) * qprod_t'(in_y);
            zz_reg <= qprod_t'(in_z) * qprod_t'(in_z);
            xy_reg <= qprod_t'(in_x) * qprod_t'(in_y);
            xz_reg <= qprod_t'(in_x) * qprod_t'(in_z);
            yz_reg <= qprod_t'(in_y) * qprod_t'(in_z);
            wx_reg <= qprod_t'(in_w) * qprod_t'(in_x);
            wy_reg <= qprod_t'(in_w) * qprod_t'(in_y);
            wz_reg <= qprod_t'(in_w) * qprod_t'(in_z);
            tg_reg <= s_axis_tuser;
            for (int j = 0; j < 3; j++) begin
                r0_reg[j] <= in_r[j];
            end
        end
        if (stage_en[STG_MAT]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    mat_reg[i][j] <= mat_next[i][j];
                end
                r1_reg[i] <= r0_reg[i];
            end
        end
    end

    // c times a vector part is 2w times it, negated toward the global frame
    always_comb begin
        cx = MAT_WIDTH'(wx_reg) <<< 1;
        cy = MAT_WIDTH'(wy_reg) <<< 1;
        cz = MAT_WIDTH'(wz_reg) <<< 1;
        if (tg_reg) begin
            cx = -cx;
            cy = -cy;
            cz = -cz;
        end
        mat_next[0][0] = MAT_WIDTH'(ww_reg) + MAT_WIDTH'(xx_reg)
                       - MAT_WIDTH'(yy_reg) - MAT_WIDTH'(zz_reg);
        mat_next[1][1] = MAT_WIDTH'(ww_reg) - MAT_WIDTH'(xx_reg)
                       + MAT_WIDTH'(yy_reg) - MAT_WIDTH'(zz_reg);
        mat_next[2][2] = MAT_WIDTH'(ww_reg) - MAT_WIDTH'(xx_reg)
                       - MAT_WIDTH'(yy_reg) + MAT_WIDTH'(zz_reg);
        mat_next[0][1] = (MAT_WIDTH'(xy_reg) <<< 1) - cz;
        mat_next[1][0] = (MAT_WIDTH'(xy_reg) <<< 1) + cz;
        mat_next[0][2] = (MAT_WIDTH'(xz_reg) <<< 1) + cy;
        mat_next[2][0] = (MAT_WIDTH'(xz_reg) <<< 1) - cy;
        mat_next[1][2] = (MAT_WIDTH'(yz_reg) <<< 1) - cx;
        mat_next[2][1] = (MAT_WIDTH'(yz_reg) <<< 1) + cx;
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        qrv_row u_row (
            .aclk     (aclk),
            .stage_en (stage_en),
            .mat_0    (mat_reg[g][0]),
            .mat_1    (mat_reg[g][1]),
            .mat_2    (mat_reg[g][2]),
            .vec_0    (r1_reg[0]),
            .vec_1    (r1_reg[1]),
            .vec_2    (r1_reg[2]),
            .res      (row_res[g]),
            .ovf      (row_ovf[g])
        );
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = vld_reg[STG_OUT];
    assign m_axis_tdata  = OUT_TDATA_W'({row_res[2], row_res[1], row_res[0]});
    assign m_axis_tuser  = row_ovf[0] || row_ovf[1] || row_ovf[2];

    localparam vec_comp_t CHK_MAX = {1'b0, {(VW - 1){1'b1}}};
    localparam vec_comp_t CHK_MIN = {1'b1, {(VW - 1){1'b0}}};

    `QRV_ASSERT_IMPLY(a_ovf_saturated, aclk, aresetn, m_axis_tvalid && m_axis_tuser, row_res[0] == CHK_MAX || row_res[0] == CHK_MIN || row_res[1] == CHK_MAX || row_res[1] == CHK_MIN || row_res[2] == CHK_MAX || row_res[2] == CHK_MIN)
    `QRV_ASSERT_IMPLY(a_empty_out_ready, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    `QRV_ASSERT(a_accept_fills, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> vld_reg[STG_QPROD])
    `QRV_ASSERT(a_stall_holds_sum, aclk, aresetn, m_axis_tvalid && !m_axis_tready && vld_reg[STG_SUM] |=> vld_reg[STG_SUM] && m_axis_tvalid)

endmodule
`default_nettype wire
